FILE: design/tvp_pkg.sv
// ----------------------------------------------------------------------------
// tvp_pkg
// Shared types and constants for the trapezoid velocity profile generator.
// ----------------------------------------------------------------------------
package tvp_pkg;

    // Profile phases, in the order they are visited
    typedef enum logic [1:0] {
        PH_RAMP_UP   = 2'd0,
        PH_HOLD_MAX  = 2'd1,
        PH_RAMP_DOWN = 2'd2,
        PH_HOLD_ZERO = 2'd3
    } t_phase;

    // Configuration register map
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_VELOCITY = 3'd0,
        CFG_RAMP_STEP    = 3'd1,
        CFG_SPIN_UP_MS   = 3'd2,
        CFG_HOLD_MAX_MS  = 3'd3,
        CFG_SPIN_DOWN_MS = 3'd4,
        CFG_HOLD_STOP_MS = 3'd5
    } t_cfg_idx;

    // Fixed field widths
    localparam int unsigned NOW_W = 32;
    localparam int unsigned VEL_W = 24;
    localparam int unsigned DUR_W = 32;
    localparam int unsigned PHASE_W = 2;

    // Register reset values
    localparam logic [VEL_W-1:0] RST_MAX_VELOCITY = 24'd8847360;  // 135.0 in 8.16
    localparam logic [VEL_W-1:0] RST_RAMP_STEP    = 24'd4424;     // about 0.0675
    localparam logic [DUR_W-1:0] RST_SPIN_UP_MS   = 32'd20000;
    localparam logic [DUR_W-1:0] RST_HOLD_MAX_MS  = 32'd20000;
    localparam logic [DUR_W-1:0] RST_SPIN_DOWN_MS = 32'd20000;
    localparam logic [DUR_W-1:0] RST_HOLD_STOP_MS = 32'd24000;

endpackage

FILE: design/trapezoid_velocity_profile.sv
// Pipeline: a tick taken into the input register moves into the output register
//   when that register is free (two register stages: input, result).
// Throughput: one tick per cycle, ticks back to back, unless the output stalls;
//   the phase/velocity add, clamp and time compare sit in the result stage.
// Reset (synchronous, active low): phase ramp up, velocity zero, not started,
//   pipeline empty, configuration registers back to their default profile.
// ----------------------------------------------------------------------------
// trapezoid_velocity_profile
// Trapezoidal velocity profile generator: ramp up, hold at maximum, ramp down,
// hold at zero, repeated, timed from a free running millisecond tick.
// ----------------------------------------------------------------------------
module trapezoid_velocity_profile #(
    parameter int unsigned TIME_BITS     = 32,
    parameter int unsigned VELOCITY_BITS = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    // tick input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [tvp_pkg::NOW_W-1:0]           i_now_ms,

    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [tvp_pkg::VEL_W-1:0]           o_velocity_setpoint,
    output logic [tvp_pkg::PHASE_W-1:0]         o_phase,

    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tvp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [tvp_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers. Velocities are kept at VELOCITY_BITS after
    // masking to the 24-bit register field; durations stay 32 bits and are
    // resized to the time width where they are compared.
    // ------------------------------------------------------------------
    logic [VELOCITY_BITS-1:0]       r_max_velocity;
    logic [VELOCITY_BITS-1:0]       r_ramp_step;
    logic [tvp_pkg::DUR_W-1:0]      r_spin_up_ms;
    logic [tvp_pkg::DUR_W-1:0]      r_hold_max_ms;
    logic [tvp_pkg::DUR_W-1:0]      r_spin_down_ms;
    logic [tvp_pkg::DUR_W-1:0]      r_hold_stop_ms;

    logic                           cfg_we;
    logic [VELOCITY_BITS-1:0]       cfg_vel;

    // The register file takes a write in every cycle
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid & o_cfg_ready;
    assign cfg_vel     = VELOCITY_BITS'(i_cfg_data[tvp_pkg::VEL_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_velocity <= VELOCITY_BITS'(tvp_pkg::RST_MAX_VELOCITY);
            r_ramp_step    <= VELOCITY_BITS'(tvp_pkg::RST_RAMP_STEP);
            r_spin_up_ms   <= tvp_pkg::RST_SPIN_UP_MS;
            r_hold_max_ms  <= tvp_pkg::RST_HOLD_MAX_MS;
            r_spin_down_ms <= tvp_pkg::RST_SPIN_DOWN_MS;
            r_hold_stop_ms <= tvp_pkg::RST_HOLD_STOP_MS;
        end else if (cfg_we) begin
            unique case (i_cfg_index)
                tvp_pkg::CFG_MAX_VELOCITY: r_max_velocity <= cfg_vel;
                tvp_pkg::CFG_RAMP_STEP:    r_ramp_step    <= cfg_vel;
                tvp_pkg::CFG_SPIN_UP_MS:   r_spin_up_ms   <= i_cfg_data;
                tvp_pkg::CFG_HOLD_MAX_MS:  r_hold_max_ms  <= i_cfg_data;
                tvp_pkg::CFG_SPIN_DOWN_MS: r_spin_down_ms <= i_cfg_data;
                tvp_pkg::CFG_HOLD_STOP_MS: r_hold_stop_ms <= i_cfg_data;
                default: ;  // indexes past the map are dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control. The input register holds one tick; it moves into
    // the result stage whenever the output register is empty or its
    // transfer completes in the same cycle.
    // ------------------------------------------------------------------
    logic                           r_in_valid;
    logic [tvp_pkg::NOW_W-1:0]      r_now_ms;
    logic                           r_out_valid;
    logic                           out_free;
    logic                           advance;
    logic                           in_take;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // Payload register: hold while the stage is full and stalled
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_now_ms <= i_now_ms;
        end
    end

    // ------------------------------------------------------------------
    // Profile state
    // ------------------------------------------------------------------
    tvp_pkg::t_phase                r_phase;
    tvp_pkg::t_phase                n_phase;
    logic [TIME_BITS-1:0]           r_phase_start;
    logic [TIME_BITS-1:0]           n_phase_start;
    logic                           r_started;
    logic [VELOCITY_BITS-1:0]       r_velocity;
    logic [VELOCITY_BITS-1:0]       n_velocity;

    logic [TIME_BITS-1:0]           now_t;
    logic [TIME_BITS-1:0]           start_eff;
    logic [TIME_BITS-1:0]           elapsed;
    logic [TIME_BITS-1:0]           duration;
    logic                           phase_done;
    logic [VELOCITY_BITS:0]         vel_sum;
    logic [VELOCITY_BITS-1:0]       vel_up;
    logic [VELOCITY_BITS-1:0]       vel_down;

    // The first tick latches its own time as the phase start
    assign now_t     = TIME_BITS'(r_now_ms);
    assign start_eff = r_started ? r_phase_start : now_t;
    assign elapsed   = now_t - start_eff;   // wraps modulo 2^TIME_BITS

    always_comb begin
        unique case (r_phase)
            tvp_pkg::PH_RAMP_UP:   duration = TIME_BITS'(r_spin_up_ms);
            tvp_pkg::PH_HOLD_MAX:  duration = TIME_BITS'(r_hold_max_ms);
            tvp_pkg::PH_RAMP_DOWN: duration = TIME_BITS'(r_spin_down_ms);
            tvp_pkg::PH_HOLD_ZERO: duration = TIME_BITS'(r_hold_stop_ms);
            default:               duration = '0;
        endcase
    end

    assign phase_done = (elapsed >= duration);

    // Saturating ramp steps
    assign vel_sum  = {1'b0, r_velocity} + {1'b0, r_ramp_step};
    assign vel_up   = (vel_sum > {1'b0, r_max_velocity}) ? r_max_velocity
                                                         : vel_sum[VELOCITY_BITS-1:0];
    assign vel_down = (r_ramp_step > r_velocity) ? '0 : (r_velocity - r_ramp_step);

    // Next phase: advance around the loop once the duration has elapsed
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            tvp_pkg::PH_RAMP_UP:   if (phase_done) n_phase = tvp_pkg::PH_HOLD_MAX;
            tvp_pkg::PH_HOLD_MAX:  if (phase_done) n_phase = tvp_pkg::PH_RAMP_DOWN;
            tvp_pkg::PH_RAMP_DOWN: if (phase_done) n_phase = tvp_pkg::PH_HOLD_ZERO;
            tvp_pkg::PH_HOLD_ZERO: if (phase_done) n_phase = tvp_pkg::PH_RAMP_UP;
            default:               n_phase = tvp_pkg::PH_RAMP_UP;
        endcase
    end

    // Velocity per phase; a finished ramp is forced to its end value
    always_comb begin
        unique case (r_phase)
            tvp_pkg::PH_RAMP_UP:   n_velocity = phase_done ? r_max_velocity : vel_up;
            tvp_pkg::PH_HOLD_MAX:  n_velocity = r_max_velocity;
            tvp_pkg::PH_RAMP_DOWN: n_velocity = phase_done ? '0 : vel_down;
            tvp_pkg::PH_HOLD_ZERO: n_velocity = '0;
            default:               n_velocity = '0;
        endcase
        n_phase_start = phase_done ? now_t : start_eff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= tvp_pkg::PH_RAMP_UP;
            r_phase_start <= '0;
            r_started     <= 1'b0;
            r_velocity    <= '0;
        end else if (advance) begin
            r_phase       <= n_phase;
            r_phase_start <= n_phase_start;
            r_started     <= 1'b1;
            r_velocity    <= n_velocity;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic [tvp_pkg::VEL_W-1:0]      r_out_velocity;
    logic [tvp_pkg::PHASE_W-1:0]    r_out_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_velocity <= tvp_pkg::VEL_W'(n_velocity);
            r_out_phase    <= n_phase;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_velocity_setpoint = r_out_velocity;
    assign o_phase             = r_out_phase;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // A tick waiting in the input stage moves on when the output is empty
    a_fill_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_out_valid) |=> r_out_valid)
        else $error("input stage did not advance into an empty output stage");

    // Phase moves by at most one step per tick, and only in loop order
    a_phase_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> (r_phase == $past(r_phase)) ||
                    (r_phase == tvp_pkg::t_phase'($past(r_phase) + 2'd1)))
        else $error("profile phase skipped a step");

    // Holding at zero always reports a stopped velocity
    a_zero_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_phase == tvp_pkg::PH_HOLD_ZERO)) |-> (o_velocity_setpoint == '0))
        else $error("nonzero velocity in hold at zero phase");

endmodule
